// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the chunked message ring fifo
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/cmrf_pkg.sv =====
// ----------------------------------------------------------------------------
// cmrf_pkg
// command codes, state types and fixed port widths of the chunked message ring
// ----------------------------------------------------------------------------
package cmrf_pkg;

    localparam int FUNC_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int MSGLEN_W  = 16;
    localparam int LEN_W     = 7;
    localparam int PENDING_W = 5;
    localparam int CNT_W     = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_MSG_BEGIN   = 3'd0,
        FUNC_CHUNK_BEGIN = 3'd1,
        FUNC_DATA        = 3'd2,
        FUNC_POP         = 3'd3,
        FUNC_STATUS      = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_MSG   = 2'd1,
        MODE_CHUNK = 2'd2,
        MODE_DROP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_META = 2'd1,
        ST_DATA = 2'd2
    } t_state;

endpackage

// ===== design/cmrf_ram.sv =====
// ----------------------------------------------------------------------------
// cmrf_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cmrf_ram #(
    parameter int AW = 5,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/chunked_message_ring_fifo.sv =====
// ----------------------------------------------------------------------------
// chunked_message_ring_fifo
// ring of DEPTH chunk slots of up to CHUNK bytes; messages are cut into
// chunks on the way in and popped one chunk at a time, with statistics
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  command   | start / busy       | i_func i_data_byte i_msg_len i_last_flag
//  result    | o_strobe (1 cycle) | o_empty_res o_out_byte o_seg_len ...
//
// begin, data byte and ignored codes leave busy low.
// status and an empty pop put their result out the cycle after the transfer.
// a pop of an n-byte chunk holds busy through its slot table read and its n
// byte reads; its bytes appear one per cycle, paced by the slot table read
// and the chunk store read port, both of which are registered.
// reset is synchronous and needs no clearing pass; results cannot be stalled.
module chunked_message_ring_fifo #(
    parameter int DEPTH = 32,
    parameter int CHUNK = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [cmrf_pkg::FUNC_W-1:0]    i_func,
    input  logic [cmrf_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic [cmrf_pkg::MSGLEN_W-1:0]  i_msg_len,
    input  logic                           i_last_flag,
    output logic                           o_strobe,
    output logic                           o_empty_res,
    output logic [cmrf_pkg::BYTE_W-1:0]    o_out_byte,
    output logic [cmrf_pkg::LEN_W-1:0]     o_seg_len,
    output logic                           o_chunk_last,
    output logic                           o_byte_last,
    output logic [cmrf_pkg::PENDING_W-1:0] o_pending,
    output logic [cmrf_pkg::PENDING_W-1:0] o_high_water,
    output logic [cmrf_pkg::CNT_W-1:0]     o_overflow_count,
    output logic [cmrf_pkg::CNT_W-1:0]     o_chunk_count,
    output logic [cmrf_pkg::CNT_W-1:0]     o_total_bytes,
    output logic [cmrf_pkg::LEN_W-1:0]     o_max_seg_len
);

    localparam int SW   = $clog2(DEPTH);
    localparam int CW   = (CHUNK > 1) ? $clog2(CHUNK) : 1;
    localparam int FW   = $clog2(CHUNK + 1);
    localparam int PW   = SW + FW;
    localparam int CMPW = (PW > cmrf_pkg::MSGLEN_W) ? PW : cmrf_pkg::MSGLEN_W;
    localparam int CNTW = cmrf_pkg::CNT_W;
    localparam logic [SW-1:0] LAST_SLOT  = SW'(DEPTH - 1);
    localparam logic [FW-1:0] CHUNK_FULL = FW'(CHUNK);

    // control state
    cmrf_pkg::t_state r_state, n_state;
    cmrf_pkg::t_mode  r_mode, n_mode;
    logic [SW-1:0]    r_write_slot, n_write_slot;
    logic [SW-1:0]    r_read_slot, n_read_slot;
    logic [cmrf_pkg::MSGLEN_W-1:0] r_rem, n_rem;
    logic [FW-1:0]    r_fill, n_fill;
    logic             r_open_last, n_open_last;
    logic [SW-1:0]    r_peak, n_peak;
    logic [CNTW-1:0]  r_overflows, n_overflows;
    logic [CNTW-1:0]  r_chunks, n_chunks;
    logic [CNTW-1:0]  r_bytes, n_bytes;
    logic [FW-1:0]    r_longest, n_longest;
    logic             r_rd_vld, n_rd_vld;
    logic             r_strobe, n_strobe;

    // pop bookkeeping and result payload
    logic [SW-1:0]    r_pop_slot, n_pop_slot;
    logic [FW-1:0]    r_pop_len, n_pop_len;
    logic             r_pop_last, n_pop_last;
    logic [FW-1:0]    r_idx, n_idx;
    logic             r_rd_blast, n_rd_blast;
    logic             r_out_empty, n_out_empty;
    logic [cmrf_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic [cmrf_pkg::LEN_W-1:0]  r_out_len, n_out_len;
    logic             r_out_last, n_out_last;
    logic             r_out_blast, n_out_blast;

    // memory ports
    logic             data_we;
    logic [SW+CW-1:0] data_waddr, data_raddr;
    logic [cmrf_pkg::BYTE_W-1:0] data_rdata;
    logic             meta_we;
    logic [FW:0]      meta_wdata, meta_rdata;

    // helpers
    logic [SW:0]      held_x;
    logic [SW-1:0]    held, held_inc, avail;
    logic             ring_full, no_room, accept;
    logic [CMPW-1:0]  room_bytes;
    logic             commit_en, commit_last;
    logic [FW-1:0]    commit_len, fill_inc;
    logic [cmrf_pkg::MSGLEN_W-1:0] rem_dec;
    logic [FW-1:0]    meta_len;

    assign held_x = (r_write_slot >= r_read_slot)
                  ? ({1'b0, r_write_slot} - {1'b0, r_read_slot})
                  : ({1'b0, r_write_slot} + (SW+1)'(DEPTH) - {1'b0, r_read_slot});
    assign held       = held_x[SW-1:0];
    assign held_inc   = held + SW'(1);
    assign ring_full  = (held == LAST_SLOT);
    assign avail      = LAST_SLOT - held;
    assign room_bytes = CMPW'(avail) * CMPW'(CHUNK);
    assign no_room    = room_bytes < CMPW'(i_msg_len);
    assign fill_inc   = r_fill + FW'(1);
    assign rem_dec    = r_rem - cmrf_pkg::MSGLEN_W'(1);
    assign meta_len   = meta_rdata[FW-1:0];

    assign busy   = (r_state != cmrf_pkg::ST_IDLE) || r_rd_vld;
    assign accept = start && !busy;

    cmrf_ram #(
        .AW (SW + CW),
        .DW (cmrf_pkg::BYTE_W)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (i_data_byte),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    // slot table: {last mark, length}, always read at the read slot
    cmrf_ram #(
        .AW (SW),
        .DW (FW + 1)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_write_slot),
        .i_wdata (meta_wdata),
        .i_raddr (r_read_slot),
        .o_rdata (meta_rdata)
    );

    assign data_waddr = {r_write_slot, r_fill[CW-1:0]};
    assign data_raddr = {r_pop_slot, r_idx[CW-1:0]};
    assign meta_we    = commit_en;
    assign meta_wdata = {commit_last, commit_len};

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_write_slot = r_write_slot;
        n_read_slot  = r_read_slot;
        n_rem        = r_rem;
        n_fill       = r_fill;
        n_open_last  = r_open_last;
        n_peak       = r_peak;
        n_overflows  = r_overflows;
        n_chunks     = r_chunks;
        n_bytes      = r_bytes;
        n_longest    = r_longest;
        n_rd_vld     = 1'b0;
        n_strobe     = 1'b0;
        n_pop_slot   = r_pop_slot;
        n_pop_len    = r_pop_len;
        n_pop_last   = r_pop_last;
        n_idx        = r_idx;
        n_rd_blast   = r_rd_blast;
        n_out_empty  = r_out_empty;
        n_out_byte   = r_out_byte;
        n_out_len    = r_out_len;
        n_out_last   = r_out_last;
        n_out_blast  = r_out_blast;
        data_we      = 1'b0;
        commit_en    = 1'b0;
        commit_len   = r_fill;
        commit_last  = 1'b0;

        case (r_state)
            cmrf_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_func)
                        cmrf_pkg::FUNC_MSG_BEGIN: begin
                            n_fill = '0;
                            n_rem  = i_msg_len;
                            if (no_room) begin
                                n_overflows = r_overflows + CNTW'(1);
                                n_mode = (i_msg_len != '0) ? cmrf_pkg::MODE_DROP
                                                           : cmrf_pkg::MODE_NONE;
                            end else begin
                                n_mode = (i_msg_len != '0) ? cmrf_pkg::MODE_MSG
                                                           : cmrf_pkg::MODE_NONE;
                            end
                        end
                        cmrf_pkg::FUNC_CHUNK_BEGIN: begin
                            n_fill      = '0;
                            n_rem       = i_msg_len;
                            n_open_last = i_last_flag;
                            if (ring_full) begin
                                n_overflows = r_overflows + CNTW'(1);
                                n_mode = (i_msg_len != '0) ? cmrf_pkg::MODE_DROP
                                                           : cmrf_pkg::MODE_NONE;
                            end else if (i_msg_len == '0) begin
                                // empty chunk goes in at once
                                commit_en   = 1'b1;
                                commit_len  = '0;
                                commit_last = i_last_flag;
                                n_mode      = cmrf_pkg::MODE_NONE;
                            end else begin
                                n_mode = cmrf_pkg::MODE_CHUNK;
                            end
                        end
                        cmrf_pkg::FUNC_DATA: begin
                            if (r_mode == cmrf_pkg::MODE_NONE || r_rem == '0) begin
                                n_mode = cmrf_pkg::MODE_NONE;
                            end else begin
                                n_rem = rem_dec;
                                if (r_mode == cmrf_pkg::MODE_DROP) begin
                                    if (rem_dec == '0) begin
                                        n_mode = cmrf_pkg::MODE_NONE;
                                    end
                                end else begin
                                    if (r_fill < CHUNK_FULL) begin
                                        data_we = 1'b1;
                                        n_fill  = fill_inc;
                                    end
                                    if (n_fill >= CHUNK_FULL || rem_dec == '0) begin
                                        commit_en  = 1'b1;
                                        commit_len = n_fill;
                                        if (r_mode == cmrf_pkg::MODE_MSG) begin
                                            commit_last = (rem_dec == '0);
                                            if (rem_dec == '0) begin
                                                n_mode = cmrf_pkg::MODE_NONE;
                                            end
                                        end else begin
                                            commit_last = r_open_last;
                                            n_mode = (rem_dec != '0) ? cmrf_pkg::MODE_DROP
                                                                     : cmrf_pkg::MODE_NONE;
                                        end
                                    end
                                end
                            end
                        end
                        cmrf_pkg::FUNC_POP: begin
                            if (held == '0) begin
                                n_strobe    = 1'b1;
                                n_out_empty = 1'b1;
                                n_out_byte  = '0;
                                n_out_len   = '0;
                                n_out_last  = 1'b0;
                                n_out_blast = 1'b1;
                            end else begin
                                n_state = cmrf_pkg::ST_META;
                            end
                        end
                        cmrf_pkg::FUNC_STATUS: begin
                            n_strobe    = 1'b1;
                            n_out_empty = 1'b0;
                            n_out_byte  = '0;
                            n_out_len   = '0;
                            n_out_last  = 1'b0;
                            n_out_blast = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cmrf_pkg::ST_META: begin
                // slot table read of the read slot has landed
                n_pop_slot  = r_read_slot;
                n_pop_len   = meta_len;
                n_pop_last  = meta_rdata[FW];
                n_idx       = '0;
                n_read_slot = (r_read_slot == LAST_SLOT) ? '0 : r_read_slot + SW'(1);
                if (meta_len == '0) begin
                    n_strobe    = 1'b1;
                    n_out_empty = 1'b0;
                    n_out_byte  = '0;
                    n_out_len   = '0;
                    n_out_last  = meta_rdata[FW];
                    n_out_blast = 1'b1;
                    n_state     = cmrf_pkg::ST_IDLE;
                end else begin
                    n_state = cmrf_pkg::ST_DATA;
                end
            end
            cmrf_pkg::ST_DATA: begin
                n_rd_vld   = 1'b1;
                n_rd_blast = ((r_idx + FW'(1)) == r_pop_len);
                if ((r_idx + FW'(1)) == r_pop_len) begin
                    n_state = cmrf_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + FW'(1);
                end
            end
            default: begin
                n_state = cmrf_pkg::ST_IDLE;
            end
        endcase

        // chunk byte from the store, once its registered read has returned
        if (r_rd_vld) begin
            n_strobe    = 1'b1;
            n_out_empty = 1'b0;
            n_out_byte  = data_rdata;
            n_out_len   = cmrf_pkg::LEN_W'(r_pop_len);
            n_out_last  = r_pop_last;
            n_out_blast = r_rd_blast;
        end

        if (commit_en) begin
            n_write_slot = (r_write_slot == LAST_SLOT) ? '0 : r_write_slot + SW'(1);
            if (held_inc > r_peak) begin
                n_peak = held_inc;
            end
            n_bytes  = r_bytes + CNTW'(commit_len);
            n_chunks = r_chunks + CNTW'(1);
            if (commit_len > r_longest) begin
                n_longest = commit_len;
            end
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cmrf_pkg::ST_IDLE;
            r_mode       <= cmrf_pkg::MODE_NONE;
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_rem        <= '0;
            r_fill       <= '0;
            r_open_last  <= 1'b0;
            r_peak       <= '0;
            r_overflows  <= '0;
            r_chunks     <= '0;
            r_bytes      <= '0;
            r_longest    <= '0;
            r_rd_vld     <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_write_slot <= n_write_slot;
            r_read_slot  <= n_read_slot;
            r_rem        <= n_rem;
            r_fill       <= n_fill;
            r_open_last  <= n_open_last;
            r_peak       <= n_peak;
            r_overflows  <= n_overflows;
            r_chunks     <= n_chunks;
            r_bytes      <= n_bytes;
            r_longest    <= n_longest;
            r_rd_vld     <= n_rd_vld;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_slot  <= n_pop_slot;
        r_pop_len   <= n_pop_len;
        r_pop_last  <= n_pop_last;
        r_idx       <= n_idx;
        r_rd_blast  <= n_rd_blast;
        r_out_empty <= n_out_empty;
        r_out_byte  <= n_out_byte;
        r_out_len   <= n_out_len;
        r_out_last  <= n_out_last;
        r_out_blast <= n_out_blast;
    end

    assign o_strobe         = r_strobe;
    assign o_empty_res      = r_out_empty;
    assign o_out_byte       = r_out_byte;
    assign o_seg_len        = r_out_len;
    assign o_chunk_last     = r_out_last;
    assign o_byte_last      = r_out_blast;
    assign o_pending        = cmrf_pkg::PENDING_W'(held);
    assign o_high_water     = cmrf_pkg::PENDING_W'(r_peak);
    assign o_overflow_count = r_overflows;
    assign o_chunk_count    = r_chunks;
    assign o_total_bytes    = r_bytes;
    assign o_max_seg_len    = cmrf_pkg::LEN_W'(r_longest);

endmodule

// ===== design/cmrf_checker.sv =====
// ----------------------------------------------------------------------------
// cmrf_checker
// port-level checks of the chunked message ring fifo, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cmrf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [cmrf_pkg::FUNC_W-1:0]   i_func,
    input logic                          o_strobe,
    input logic                          o_empty_res,
    input logic                          o_byte_last,
    input logic [cmrf_pkg::LEN_W-1:0]    o_seg_len
);

    logic xfer;
    logic is_status, is_pop, is_quiet;

    assign xfer      = start && !busy;
    assign is_status = xfer && (i_func == cmrf_pkg::FUNC_STATUS);
    assign is_pop    = xfer && (i_func == cmrf_pkg::FUNC_POP);
    assign is_quiet  = xfer && (i_func == cmrf_pkg::FUNC_MSG_BEGIN
                             || i_func == cmrf_pkg::FUNC_CHUNK_BEGIN
                             || i_func == cmrf_pkg::FUNC_DATA);

    // status answers in the very next cycle with a single result
    `ASSERT_NXT(a_status_result, i_clk, i_rst_n, is_status, o_strobe && o_byte_last && !o_empty_res)

    // a pop either answers at once or goes busy fetching its chunk
    `ASSERT_NXT(a_pop_progress, i_clk, i_rst_n, is_pop, o_strobe || busy)

    // an empty-ring answer closes the run and carries no length
    `ASSERT_IMP(a_empty_shape, i_clk, i_rst_n, o_strobe && o_empty_res, o_byte_last && (o_seg_len == '0))

    // pushes and data bytes never produce a result
    `ASSERT_NXT(a_push_silent, i_clk, i_rst_n, is_quiet, !o_strobe)

endmodule

bind chunked_message_ring_fifo cmrf_checker u_cmrf_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for chunked_message_ring_fifo: a queue-fed driver sends
// directed and random commands over start/busy, a predictor tracks the ring
// and its statistics, and a monitor checks every strobed result in order
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH        = 32;
    localparam int CHUNK        = 64;
    localparam int RANDOM_CMDS  = 470;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_PRINTED  = 40;
    localparam int SA_W         = $clog2(DEPTH);
    localparam int BA_W         = $clog2(DEPTH * CHUNK);

    localparam int FUNC_W    = cmrf_pkg::FUNC_W;
    localparam int BYTE_W    = cmrf_pkg::BYTE_W;
    localparam int MSGLEN_W  = cmrf_pkg::MSGLEN_W;
    localparam int LEN_W     = cmrf_pkg::LEN_W;
    localparam int PENDING_W = cmrf_pkg::PENDING_W;
    localparam int CNT_W     = cmrf_pkg::CNT_W;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [BYTE_W-1:0]   data;
        logic [MSGLEN_W-1:0] len;
        logic                flag;
    } t_ring_cmd;

    typedef struct {
        logic                 empty_res;
        logic [BYTE_W-1:0]    out_byte;
        logic [LEN_W-1:0]     seg_len;
        logic                 chunk_last;
        logic                 byte_last;
        logic [PENDING_W-1:0] pending;
        logic [PENDING_W-1:0] high_water;
        logic [CNT_W-1:0]     overflow_count;
        logic [CNT_W-1:0]     chunk_count;
        logic [CNT_W-1:0]     total_bytes;
        logic [LEN_W-1:0]     max_seg_len;
    } t_ring_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func      = '0;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic [MSGLEN_W-1:0]  i_msg_len   = '0;
    logic                 i_last_flag = 1'b0;
    logic                 o_strobe;
    logic                 o_empty_res;
    logic [BYTE_W-1:0]    o_out_byte;
    logic [LEN_W-1:0]     o_seg_len;
    logic                 o_chunk_last;
    logic                 o_byte_last;
    logic [PENDING_W-1:0] o_pending;
    logic [PENDING_W-1:0] o_high_water;
    logic [CNT_W-1:0]     o_overflow_count;
    logic [CNT_W-1:0]     o_chunk_count;
    logic [CNT_W-1:0]     o_total_bytes;
    logic [LEN_W-1:0]     o_max_seg_len;

    chunked_message_ring_fifo #(
        .DEPTH(DEPTH),
        .CHUNK(CHUNK)
    ) DUT (.*);

    // predicted ring contents and statistics
    logic [BYTE_W-1:0] ring_bytes [DEPTH*CHUNK];
    logic [LEN_W-1:0]  slot_len   [DEPTH];
    logic              slot_lst   [DEPTH];
    int unsigned       wr_slot = 0;
    int unsigned       rd_slot = 0;
    int unsigned       remain  = 0;
    int unsigned       fill    = 0;
    int unsigned       peak    = 0;
    int unsigned       longest = 0;
    cmrf_pkg::t_mode   mode      = cmrf_pkg::MODE_NONE;
    logic              mode_last = 1'b0;
    logic [CNT_W-1:0]  ovf_total    = '0;
    logic [CNT_W-1:0]  chunks_total = '0;
    logic [CNT_W-1:0]  bytes_total  = '0;

    t_ring_cmd    cmd_queue[$];
    t_ring_result due_results[$];
    t_ring_cmd    next_cmd;

    int err_count  = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int gen_count  = 0;
    int gap_left   = 0;
    int calm_left  = 0;
    bit xfer_taken = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int unsigned ring_held();
        if (wr_slot >= rd_slot) return wr_slot - rd_slot;
        return DEPTH - (rd_slot - wr_slot);
    endfunction

    function automatic int unsigned next_slot(int unsigned s);
        return (s + 1 >= DEPTH) ? 0 : s + 1;
    endfunction

    function automatic void commit_chunk(logic last);
        slot_len[SA_W'(wr_slot)] = LEN_W'(fill);
        slot_lst[SA_W'(wr_slot)] = last;
        wr_slot = next_slot(wr_slot);
        if (ring_held() > peak) peak = ring_held();
        bytes_total  = bytes_total + CNT_W'(fill);
        chunks_total = chunks_total + CNT_W'(1);
        if (fill > longest) longest = fill;
        fill = 0;
    endfunction

    function automatic void queue_result(logic e, logic [BYTE_W-1:0] b, int unsigned n,
                                         logic last, logic blast);
        t_ring_result r;
        r.empty_res      = e;
        r.out_byte       = b;
        r.seg_len        = LEN_W'(n);
        r.chunk_last     = last;
        r.byte_last      = blast;
        r.pending        = PENDING_W'(ring_held());
        r.high_water     = PENDING_W'(peak);
        r.overflow_count = ovf_total;
        r.chunk_count    = chunks_total;
        r.total_bytes    = bytes_total;
        r.max_seg_len    = LEN_W'(longest);
        due_results.push_back(r);
    endfunction

    function automatic void ring_apply_cmd(t_ring_cmd c);
        int unsigned need;
        int unsigned avail;
        int unsigned s;
        int unsigned n;
        logic        last;
        case (c.func)
            cmrf_pkg::FUNC_MSG_BEGIN: begin
                need   = (32'(c.len) + CHUNK - 1) / CHUNK;
                avail  = DEPTH - 1 - ring_held();
                fill   = 0;
                remain = 32'(c.len);
                if (avail < need) ovf_total = ovf_total + CNT_W'(1);
                if (c.len == 0) mode = cmrf_pkg::MODE_NONE;
                else if (avail < need) mode = cmrf_pkg::MODE_DROP;
                else mode = cmrf_pkg::MODE_MSG;
            end
            cmrf_pkg::FUNC_CHUNK_BEGIN: begin
                fill      = 0;
                remain    = 32'(c.len);
                mode_last = c.flag;
                if (ring_held() == DEPTH - 1) begin
                    ovf_total = ovf_total + CNT_W'(1);
                    if (c.len == 0) mode = cmrf_pkg::MODE_NONE;
                    else mode = cmrf_pkg::MODE_DROP;
                end else if (c.len == 0) begin
                    commit_chunk(c.flag);
                    mode = cmrf_pkg::MODE_NONE;
                end else begin
                    mode = cmrf_pkg::MODE_CHUNK;
                end
            end
            cmrf_pkg::FUNC_DATA: begin
                if (mode == cmrf_pkg::MODE_NONE || remain == 0) begin
                    mode = cmrf_pkg::MODE_NONE;
                end else begin
                    remain--;
                    if (mode == cmrf_pkg::MODE_DROP) begin
                        if (remain == 0) mode = cmrf_pkg::MODE_NONE;
                    end else begin
                        if (fill < CHUNK) begin
                            ring_bytes[BA_W'(wr_slot*CHUNK + fill)] = c.data;
                            fill++;
                        end
                        if (fill >= CHUNK || remain == 0) begin
                            if (mode == cmrf_pkg::MODE_MSG) begin
                                commit_chunk(remain == 0);
                                if (remain == 0) mode = cmrf_pkg::MODE_NONE;
                            end else begin
                                // single chunk: excess bytes are swallowed in drop mode
                                commit_chunk(mode_last);
                                if (remain != 0) mode = cmrf_pkg::MODE_DROP;
                                else mode = cmrf_pkg::MODE_NONE;
                            end
                        end
                    end
                end
            end
            cmrf_pkg::FUNC_POP: begin
                if (ring_held() == 0) begin
                    queue_result(1'b1, '0, 0, 1'b0, 1'b1);
                end else begin
                    s = rd_slot;
                    n = 32'(slot_len[SA_W'(s)]);
                    if (n > CHUNK) n = CHUNK;
                    last = slot_lst[SA_W'(s)];
                    // pending is reported after the slot is released
                    rd_slot = next_slot(rd_slot);
                    if (n == 0) begin
                        queue_result(1'b0, '0, 0, last, 1'b1);
                    end else begin
                        for (int unsigned i = 0; i < n; i++)
                            queue_result(1'b0, ring_bytes[BA_W'(s*CHUNK + i)], n, last,
                                         i + 1 == n);
                    end
                end
            end
            cmrf_pkg::FUNC_STATUS: queue_result(1'b0, '0, 0, 1'b0, 1'b1);
            default: ;
        endcase
    endfunction

    task automatic log_error(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    task automatic check_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        if (got !== want)
            log_error($sformatf("result %0d: %s got %0h expected %0h",
                                n_checked, name, got, want));
    endtask

    task automatic check_result();
        t_ring_result w;
        if (due_results.size() == 0) begin
            log_error($sformatf("result strobe with no result due, byte %0h", o_out_byte));
        end else begin
            w = due_results.pop_front();
            n_checked++;
            check_field("empty_res", CNT_W'(o_empty_res), CNT_W'(w.empty_res));
            check_field("out_byte", CNT_W'(o_out_byte), CNT_W'(w.out_byte));
            check_field("seg_len", CNT_W'(o_seg_len), CNT_W'(w.seg_len));
            check_field("chunk_last", CNT_W'(o_chunk_last), CNT_W'(w.chunk_last));
            check_field("byte_last", CNT_W'(o_byte_last), CNT_W'(w.byte_last));
            check_field("pending", CNT_W'(o_pending), CNT_W'(w.pending));
            check_field("high_water", CNT_W'(o_high_water), CNT_W'(w.high_water));
            check_field("overflow_count", o_overflow_count, w.overflow_count);
            check_field("chunk_count", o_chunk_count, w.chunk_count);
            check_field("total_bytes", o_total_bytes, w.total_bytes);
            check_field("max_seg_len", CNT_W'(o_max_seg_len), CNT_W'(w.max_seg_len));
        end
    endtask

    // monitor: results first, then the command taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) check_result();
            xfer_taken = start && !busy;
            if (xfer_taken) begin
                next_cmd.func = i_func;
                next_cmd.data = i_data_byte;
                next_cmd.len  = i_msg_len;
                next_cmd.flag = i_last_flag;
                ring_apply_cmd(next_cmd);
                n_accepted++;
            end
        end else begin
            xfer_taken = 1'b0;
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // driver: a command stays on the ports until its transfer
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || xfer_taken)) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (cmd_queue.size() > 0) begin
                next_cmd = cmd_queue.pop_front();
                start       <= 1'b1;
                i_func      <= next_cmd.func;
                i_data_byte <= next_cmd.data;
                i_msg_len   <= next_cmd.len;
                i_last_flag <= next_cmd.flag;
                gap_left = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    function automatic void queue_item(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] d,
                                       logic [MSGLEN_W-1:0] l, logic lf);
        t_ring_cmd c;
        c.func = f;
        c.data = d;
        c.len  = l;
        c.flag = lf;
        cmd_queue.push_back(c);
        gen_count++;
    endfunction

    function automatic void queue_data(logic [BYTE_W-1:0] d);
        queue_item(cmrf_pkg::FUNC_DATA, d, MSGLEN_W'($urandom), 1'($urandom));
    endfunction

    function automatic void queue_msg(logic [MSGLEN_W-1:0] l);
        queue_item(cmrf_pkg::FUNC_MSG_BEGIN, BYTE_W'($urandom), l, 1'($urandom));
    endfunction

    function automatic void queue_single(logic [MSGLEN_W-1:0] l, logic lf);
        queue_item(cmrf_pkg::FUNC_CHUNK_BEGIN, BYTE_W'($urandom), l, lf);
    endfunction

    function automatic void queue_cmd(logic [FUNC_W-1:0] f);
        queue_item(f, BYTE_W'($urandom), MSGLEN_W'($urandom), 1'($urandom));
    endfunction

    function automatic void queue_bytes(int unsigned n);
        for (int unsigned i = 0; i < n; i++) queue_data(BYTE_W'($urandom));
    endfunction

    function automatic int unsigned pick_len();
        int unsigned w;
        w = $urandom_range(0, 99);
        if (w < 3)  return 0;
        if (w < 88) return $urandom_range(1, 8);
        if (w < 97) return $urandom_range(9, 40);
        if (w < 99) return $urandom_range(56, 72);
        return $urandom_range(120, 140);
    endfunction

    // mostly the announced count, sometimes cut short or overrun
    function automatic int unsigned trim_count(int unsigned len);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)  return $urandom_range(0, len);
        if (r < 12) return len + $urandom_range(1, 2);
        return len;
    endfunction

    initial begin : stimulus
        int unsigned len;
        int unsigned seg_left;
        int unsigned pop_pct;
        int unsigned r;
        int unsigned k;
        bit          fill_bias;
        int          target;

        queue_cmd(cmrf_pkg::FUNC_STATUS);
        queue_cmd(cmrf_pkg::FUNC_POP);      // empty ring
        queue_single(16'd0, 1'b1);          // empty chunk pushed at once
        queue_cmd(cmrf_pkg::FUNC_POP);      // zero-length chunk
        queue_data(8'hA5);                  // nothing open
        queue_msg(16'd0);
        queue_data(8'h5A);
        queue_single(16'd2, 1'b0);
        queue_data(8'h00);
        queue_data(8'hFF);
        queue_msg(16'hFFFF);                // no room, bytes dropped
        queue_data(8'h12);
        queue_data(8'h34);
        queue_cmd(FUNC_UNUSED_LO);
        queue_cmd(FUNC_UNUSED_LO + 3'd1);
        queue_cmd(FUNC_UNUSED_HI);
        queue_msg(16'd3);
        queue_data(8'h81);
        queue_single(16'd1, 1'b1);          // abandons the open message
        queue_data(8'hFF);
        queue_data(8'h00);                  // beyond the announced count
        queue_cmd(cmrf_pkg::FUNC_POP);
        queue_cmd(cmrf_pkg::FUNC_POP);
        queue_cmd(cmrf_pkg::FUNC_POP);
        queue_cmd(cmrf_pkg::FUNC_STATUS);

        // alternate fill-heavy and drain-heavy stretches to reach a full ring
        target    = RANDOM_CMDS;
        fill_bias = 1'b1;
        seg_left  = 70;
        while (gen_count < target) begin
            if (seg_left == 0) begin
                fill_bias = !fill_bias;
                seg_left  = $urandom_range(30, 60);
            end
            seg_left--;
            pop_pct = fill_bias ? 4 : 45;
            r = $urandom_range(0, 99);
            if (r < pop_pct) begin
                repeat ($urandom_range(1, fill_bias ? 1 : 4)) queue_cmd(cmrf_pkg::FUNC_POP);
            end else begin
                k = $urandom_range(0, 99);
                if (k < 40) begin
                    len = fill_bias ? $urandom_range(0, 4) : pick_len();
                    queue_msg(MSGLEN_W'(len));
                    queue_bytes(trim_count(len));
                end else if (k == 40) begin
                    len = CHUNK + $urandom_range(1, 6);
                    queue_single(MSGLEN_W'(len), 1'($urandom));
                    queue_bytes(len);
                end else if (k == 41) begin
                    queue_single(MSGLEN_W'($urandom), 1'($urandom));
                    queue_bytes($urandom_range(0, 8));
                end else if (k < 75) begin
                    len = fill_bias ? $urandom_range(0, 4) : pick_len();
                    queue_single(MSGLEN_W'(len), 1'($urandom));
                    queue_bytes(trim_count(len));
                end else if (k < 85) begin
                    queue_cmd(cmrf_pkg::FUNC_STATUS);
                end else if (k < 92) begin
                    queue_msg(MSGLEN_W'($urandom));
                    queue_bytes($urandom_range(0, 3));
                end else if (k < 96) begin
                    queue_cmd(FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)));
                end else begin
                    queue_data(BYTE_W'($urandom));
                end
            end
        end
    end

    initial begin : finish_run
        wait (i_rst_n);
        while (cmd_queue.size() != 0 || start) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d commands taken, %0d results checked, %0d mismatches",
                 n_accepted, n_checked, err_count);
        $display("summary: peak %0d chunks held, %0d chunks pushed, %0d overflows, longest %0d",
                 peak, chunks_total, ovf_total, longest);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
